// ----- hdl/cnea_pkg.sv -----
// shared types and constants for the complex normal-equation accumulator
// no dependencies; imported by every module of the block
package cnea_pkg;

  // defaults for the top-level parameters
  localparam int COEFFS_DEF      = 16;
  localparam int ACC_BITS_DEF    = 48;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field and port widths
  localparam int OUT_BITS    = 48;
  localparam int IN_DATA_W   = 40;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 96;
  localparam int OUT_USER_W  = 1;
  localparam int SAMPLE_WIDE = 40;

  // item kinds
  localparam logic [1:0] KIND_ELEM  = 2'd0;
  localparam logic [1:0] KIND_RHS   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // read targets
  localparam logic [1:0] TGT_GRAM   = 2'd0;
  localparam logic [1:0] TGT_VEC    = 2'd1;
  localparam logic [1:0] TGT_ENERGY = 2'd2;

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_MAC,
    ST_RD
  } state_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic row_we;
    logic row_wzero;
    logic row_re;
    logic prod_en;
    logic prod_first;
    logic sum_en;
    logic gram_re;
    logic wb_en;
    logic gram_clr;
    logic sat_clr;
    logic out_load;
    logic out_zero;
    logic out_conj;
  } ctrl_t;

endpackage

// ----- hdl/cnea_ctrl.sv -----
// sequencer: clearing pass, triangle sweep counters, read address decode
// depends on cnea_pkg
module cnea_ctrl import cnea_pkg::*; #(
  parameter int COEFFS = COEFFS_DEF,
  localparam int N     = COEFFS + 1,
  localparam int TRI   = (N * (N + 1)) / 2,
  localparam int IW    = $clog2(N),
  localparam int KW    = $clog2(TRI)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic [1:0]    kind,
  input  logic [3:0]    col_index,
  input  logic [3:0]    row_index,
  input  logic [1:0]    read_target,
  input  logic          out_free,
  output logic          ready,
  output ctrl_t         ctrl,
  output logic [IW-1:0] row_waddr,
  output logic [IW-1:0] row_raddr,
  output logic [KW-1:0] gram_raddr,
  output logic [KW-1:0] gram_waddr
);

  state_t        state, state_next;
  logic [IW-1:0] i_idx, j_idx;
  logic [KW-1:0] k_idx;
  logic          issuing;
  logic          v1, v2, v3, f1;
  logic [KW-1:0] k1, k2, k3;
  logic          rd_zero, rd_conj;
  logic [6:0]    row_w, col_w, tri_a, tri_b;
  logic          rd_ok, rd_cj;
  logic [KW-1:0] rd_addr;

  // packed upper-triangle index, row-major
  function automatic logic [KW-1:0] tri_index(input logic [6:0] a, input logic [6:0] b);
    logic [13:0] aw, t;
    aw = 14'(a);
    t  = aw * 14'(N) - ((aw * (aw - 14'd1)) >> 1) + 14'(b) - aw;
    return KW'(t);
  endfunction

  // read address decode; the vector and energy live in the extra column
  always_comb begin
    row_w = 7'(row_index);
    col_w = 7'(col_index);
    rd_ok = 1'b0;
    rd_cj = 1'b0;
    tri_a = 7'(N - 1);
    tri_b = 7'(N - 1);
    case (read_target)
      TGT_GRAM: begin
        rd_ok = (row_w < 7'(COEFFS)) && (col_w < 7'(COEFFS));
        if (row_w > col_w) begin
          rd_cj = 1'b1;
          tri_a = col_w;
          tri_b = row_w;
        end else begin
          tri_a = row_w;
          tri_b = col_w;
        end
      end
      TGT_VEC: begin
        rd_ok = row_w < 7'(COEFFS);
        tri_a = row_w;
      end
      TGT_ENERGY: rd_ok = 1'b1;
      default: rd_ok = 1'b0;
    endcase
    rd_addr = tri_index(tri_a, tri_b);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLR: begin
        if (k_idx == KW'(TRI - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (kind)
            KIND_RHS:   state_next = ST_MAC;
            KIND_CLEAR: state_next = ST_CLR;
            KIND_READ:  state_next = ST_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_MAC: begin
        if (!issuing && !v1 && !v2 && !v3) state_next = ST_IDLE;
      end
      ST_RD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl            = '0;
    ready           = (state == ST_IDLE);
    row_waddr       = j_idx;
    row_raddr       = j_idx;
    gram_raddr      = k2;
    gram_waddr      = k3;
    ctrl.prod_en    = v1;
    ctrl.prod_first = f1;
    ctrl.sum_en     = v2;
    ctrl.gram_re    = v2;
    ctrl.wb_en      = v3;
    case (state)
      ST_CLR: begin
        ctrl.gram_clr  = 1'b1;
        gram_waddr     = k_idx;
        row_waddr      = IW'(k_idx);
        ctrl.row_we    = k_idx < KW'(N);
        ctrl.row_wzero = 1'b1;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (kind)
            KIND_ELEM: begin
              ctrl.row_we = col_w < 7'(COEFFS);
              row_waddr   = IW'(col_index);
            end
            KIND_RHS: begin
              ctrl.row_we = 1'b1;
              row_waddr   = IW'(N - 1);
            end
            KIND_CLEAR: ctrl.sat_clr = 1'b1;
            KIND_READ: begin
              ctrl.gram_re = 1'b1;
              gram_raddr   = rd_addr;
            end
            default: ctrl.sat_clr = 1'b0;
          endcase
        end
      end
      ST_MAC: begin
        // element i is last read at (i,i), so it is zeroed as it is read
        if (issuing) begin
          ctrl.row_re = 1'b1;
          if (i_idx == j_idx) begin
            ctrl.row_we    = 1'b1;
            ctrl.row_wzero = 1'b1;
          end
        end
      end
      ST_RD: begin
        ctrl.out_load = out_free;
        ctrl.out_zero = rd_zero;
        ctrl.out_conj = rd_conj;
      end
      default: ctrl.out_load = 1'b0;
    endcase
  end

  // state, sweep counters and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      k_idx   <= '0;
      i_idx   <= '0;
      j_idx   <= '0;
      issuing <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= (state == ST_MAC) && issuing;
      v2    <= v1;
      v3    <= v2;
      case (state)
        ST_CLR: k_idx <= k_idx + 1'b1;
        ST_IDLE: begin
          if (in_fire && kind == KIND_RHS) begin
            i_idx   <= '0;
            j_idx   <= '0;
            k_idx   <= '0;
            issuing <= 1'b1;
          end else if (in_fire && kind == KIND_CLEAR) begin
            k_idx <= '0;
          end
        end
        ST_MAC: begin
          if (issuing) begin
            k_idx <= k_idx + 1'b1;
            if (j_idx == IW'(N - 1)) begin
              if (i_idx == IW'(N - 1)) issuing <= 1'b0;
              i_idx <= i_idx + 1'b1;
              j_idx <= i_idx + 1'b1;
            end else begin
              j_idx <= j_idx + 1'b1;
            end
          end
        end
        default: k_idx <= k_idx;
      endcase
    end
  end

  // entry addresses follow the valids down the pipeline
  always_ff @(posedge clk) begin
    f1 <= (i_idx == j_idx);
    k1 <= k_idx;
    k2 <= k1;
    k3 <= k2;
    if (state == ST_IDLE && in_fire && kind == KIND_READ) begin
      rd_zero <= !rd_ok;
      rd_conj <= rd_cj;
    end
  end

endmodule

// ----- hdl/cnea_row_mem.sv -----
// row buffer memory and the complex product stage
// depends on cnea_pkg
module cnea_row_mem import cnea_pkg::*; #(
  parameter int COEFFS      = COEFFS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int N          = COEFFS + 1,
  localparam int IW         = $clog2(N),
  localparam int PW         = 2 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  ctrl_t                         ctrl,
  input  logic [IW-1:0]                 waddr,
  input  logic [IW-1:0]                 raddr,
  input  logic signed [SAMPLE_BITS-1:0] in_re,
  input  logic signed [SAMPLE_BITS-1:0] in_im,
  output logic signed [PW-1:0]          p_rr,
  output logic signed [PW-1:0]          p_ii,
  output logic signed [PW-1:0]          p_ri,
  output logic signed [PW-1:0]          p_ir
);

  logic [PW-1:0]                 mem [N];
  logic [PW-1:0]                 rdata;
  logic [PW-1:0]                 wdata;
  logic signed [SAMPLE_BITS-1:0] ai_re, ai_im;
  logic signed [SAMPLE_BITS-1:0] x_re, x_im, y_re, y_im;

  // element write, rhs write, or zeroing
  assign wdata = ctrl.row_wzero ? '0 : {in_im, in_re};

  // row memory, read-first
  always_ff @(posedge clk) begin
    if (ctrl.row_we) mem[waddr] <= wdata;
    if (ctrl.row_re) rdata <= mem[raddr];
  end

  // a_i is the first element read in each triangle row
  always_comb begin
    y_re = rdata[SAMPLE_BITS-1:0];
    y_im = rdata[PW-1:SAMPLE_BITS];
    x_re = ctrl.prod_first ? y_re : ai_re;
    x_im = ctrl.prod_first ? y_im : ai_im;
  end

  // four partial products of conj(a_i) * a_j
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      if (ctrl.prod_first) begin
        ai_re <= y_re;
        ai_im <= y_im;
      end
      p_rr <= x_re * y_re;
      p_ii <= x_im * y_im;
      p_ri <= x_re * y_im;
      p_ir <= x_im * y_re;
    end
  end

endmodule

// ----- hdl/cnea_gram_acc.sv -----
// gram memory with saturating read-modify-write and the sticky flag
// depends on cnea_pkg
module cnea_gram_acc import cnea_pkg::*; #(
  parameter int COEFFS      = COEFFS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int N          = COEFFS + 1,
  localparam int TRI        = (N * (N + 1)) / 2,
  localparam int KW         = $clog2(TRI),
  localparam int PW         = 2 * SAMPLE_BITS,
  localparam int DW         = PW + 1,
  localparam int SW         = ((ACC_BITS > DW) ? ACC_BITS : DW) + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_t                      ctrl,
  input  logic [KW-1:0]              raddr,
  input  logic [KW-1:0]              waddr,
  input  logic signed [PW-1:0]       p_rr,
  input  logic signed [PW-1:0]       p_ii,
  input  logic signed [PW-1:0]       p_ri,
  input  logic signed [PW-1:0]       p_ir,
  output logic signed [ACC_BITS-1:0] rd_re,
  output logic signed [ACC_BITS-1:0] rd_im,
  output logic                       sat
);

  logic [2*ACC_BITS-1:0] mem [TRI];
  logic [2*ACC_BITS-1:0] rdata;
  logic [DW-1:0]         d_re, d_im;
  logic [ACC_BITS-1:0]   new_re, new_im;
  logic                  clip_re, clip_im;

  // clipped sum, clip flag in the top bit
  function automatic logic [ACC_BITS:0] sat_add(input logic [ACC_BITS-1:0] acc,
                                                input logic [DW-1:0] d);
    logic signed [SW-1:0]   s;
    logic [SW-ACC_BITS:0]   hi;
    s  = SW'($signed(acc)) + SW'($signed(d));
    hi = s[SW-1:ACC_BITS-1];
    if ((&hi) || !(|hi)) return {1'b0, s[ACC_BITS-1:0]};
    else if (s[SW-1]) return {1'b1, 1'b1, {(ACC_BITS-1){1'b0}}};
    else return {1'b1, 1'b0, {(ACC_BITS-1){1'b1}}};
  endfunction

  // complex product sums
  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      d_re <= {p_rr[PW-1], p_rr} + {p_ii[PW-1], p_ii};
      d_im <= {p_ri[PW-1], p_ri} - {p_ir[PW-1], p_ir};
    end
  end

  // saturating add on the entry read last cycle
  always_comb begin
    {clip_re, new_re} = sat_add(rdata[ACC_BITS-1:0], d_re);
    {clip_im, new_im} = sat_add(rdata[2*ACC_BITS-1:ACC_BITS], d_im);
  end

  // gram memory: clearing pass or write-back, one read port
  always_ff @(posedge clk) begin
    if (ctrl.gram_clr) mem[waddr] <= '0;
    else if (ctrl.wb_en) mem[waddr] <= {new_im, new_re};
    if (ctrl.gram_re) rdata <= mem[raddr];
  end

  // sticky saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 1'b0;
    end else if (ctrl.sat_clr) begin
      sat <= 1'b0;
    end else if (ctrl.wb_en && (clip_re || clip_im)) begin
      sat <= 1'b1;
    end
  end

  assign rd_re = rdata[ACC_BITS-1:0];
  assign rd_im = rdata[2*ACC_BITS-1:ACC_BITS];

endmodule

// ----- hdl/complex_normal_equation_accumulator.sv -----
// top level of the complex normal-equation accumulator
// depends on cnea_pkg, cnea_ctrl, cnea_row_mem, cnea_gram_acc
//
//   channel  dir  beat contents
//   s_axis   in   tuser: kind, read_target; tdata: col_index, re_part, im_part, row_index
//   m_axis   out  tuser: saturated; tdata: out_re, out_im
//
// an element beat is taken with s_axis staying ready; a clear beat starts a clearing pass over
// all (COEFFS+1)*(COEFFS+2)/2 gram entries, as does reset, with s_axis held off.
// an rhs beat runs the triangle sweep through the single complex multiply-accumulate and the
// one gram read port, with s_axis held off until the sweep has drained.
// a read beat fetches the gram entry; the result then sits in an output register, so further
// beats are taken while it waits, and a second read waits until m_axis takes the first.
module complex_normal_equation_accumulator import cnea_pkg::*; #(
  parameter int COEFFS      = COEFFS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int N          = COEFFS + 1,
  localparam int TRI        = (N * (N + 1)) / 2,
  localparam int IW         = $clog2(N),
  localparam int KW         = $clog2(TRI),
  localparam int PW         = 2 * SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // col_index[3:0], re_part[19:4], im_part[35:20], row_index[39:36]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0], read_target[3:2]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_re[47:0], out_im[95:48]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // saturated[0]
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};

  ctrl_t                         ctrl;
  logic                          in_fire, out_free;
  logic [SAMPLE_WIDE-1:0]        re_wide, im_wide;
  logic signed [SAMPLE_BITS-1:0] in_re, in_im;
  logic [IW-1:0]                 row_waddr, row_raddr;
  logic [KW-1:0]                 gram_raddr, gram_waddr;
  logic signed [PW-1:0]          p_rr, p_ii, p_ri, p_ir;
  logic signed [ACC_BITS-1:0]    rd_re, rd_im, im_neg, res_re, res_im;
  logic                          sat;
  logic [OUT_BITS-1:0]           out_re, out_im;
  logic                          out_sat, out_valid;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;

  // samples use their low SAMPLE_BITS bits
  assign re_wide = SAMPLE_WIDE'(s_axis_tdata[19:4]);
  assign im_wide = SAMPLE_WIDE'(s_axis_tdata[35:20]);
  assign in_re   = re_wide[SAMPLE_BITS-1:0];
  assign in_im   = im_wide[SAMPLE_BITS-1:0];

  cnea_ctrl #(
    .COEFFS (COEFFS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .kind        (s_axis_tuser[1:0]),
    .col_index   (s_axis_tdata[3:0]),
    .row_index   (s_axis_tdata[39:36]),
    .read_target (s_axis_tuser[3:2]),
    .out_free    (out_free),
    .ready       (s_axis_tready),
    .ctrl        (ctrl),
    .row_waddr   (row_waddr),
    .row_raddr   (row_raddr),
    .gram_raddr  (gram_raddr),
    .gram_waddr  (gram_waddr)
  );

  cnea_row_mem #(
    .COEFFS      (COEFFS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_row_mem (
    .clk   (clk),
    .ctrl  (ctrl),
    .waddr (row_waddr),
    .raddr (row_raddr),
    .in_re (in_re),
    .in_im (in_im),
    .p_rr  (p_rr),
    .p_ii  (p_ii),
    .p_ri  (p_ri),
    .p_ir  (p_ir)
  );

  cnea_gram_acc #(
    .COEFFS      (COEFFS),
    .ACC_BITS    (ACC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_gram_acc (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .raddr (gram_raddr),
    .waddr (gram_waddr),
    .p_rr  (p_rr),
    .p_ii  (p_ii),
    .p_ri  (p_ri),
    .p_ir  (p_ir),
    .rd_re (rd_re),
    .rd_im (rd_im),
    .sat   (sat)
  );

  // lower entries read as the conjugate, negation clipped at the top
  always_comb begin
    im_neg = (rd_im == ACC_MIN) ? ACC_MAX : -rd_im;
    res_re = ctrl.out_zero ? '0 : rd_re;
    res_im = ctrl.out_zero ? '0 : (ctrl.out_conj ? im_neg : rd_im);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_re  <= OUT_BITS'(res_re);
      out_im  <= OUT_BITS'(res_im);
      out_sat <= sat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_im, out_re};
  assign m_axis_tuser  = out_sat;

endmodule

// ----- tb/cnea_gram_checker.sv -----
// checker for the complex normal-equation accumulator: mirrors the gram, vector and energy
// stores from accepted s_axis beats and compares each m_axis beat with the predicted read
// depends on cnea_pkg
module cnea_gram_checker import cnea_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // col_index[3:0], re_part[19:4], im_part[35:20], row_index[39:36]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0], read_target[3:2]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_re[47:0], out_im[95:48]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // saturated[0]
  input  logic [OUT_USER_W-1:0] m_axis_tuser,
  output int                    mismatches,
  output int                    reads_pending
);

  localparam int     NC         = COEFFS_DEF;
  localparam longint ACC_MAX    = (longint'(1) <<< (ACC_BITS_DEF - 1)) - 1;
  localparam longint ACC_MIN    = -ACC_MAX - 1;

  typedef struct packed {
    logic [OUT_BITS-1:0] re;
    logic [OUT_BITS-1:0] im;
    logic                sat;
  } readback_t;

  // mirrored stores
  longint    row_re  [NC];
  longint    row_im  [NC];
  longint    gram_re [NC][NC];
  longint    gram_im [NC][NC];
  longint    vec_re  [NC];
  longint    vec_im  [NC];
  longint    energy;
  logic      sat_seen;
  readback_t reads_awaited [$];
  int        fault_count = 0;

  // saturating accumulate, sets the sticky flag on clipping
  function automatic longint sat_accumulate(longint acc, longint d);
    if (d > 0 && acc > ACC_MAX - d) begin
      sat_seen = 1'b1;
      return ACC_MAX;
    end
    if (d < 0 && acc < ACC_MIN - d) begin
      sat_seen = 1'b1;
      return ACC_MIN;
    end
    return acc + d;
  endfunction

  function automatic longint to_sample(logic [15:0] v);
    return longint'($signed(v[SAMPLE_BITS_DEF-1:0]));
  endfunction

  task automatic clear_stores();
    for (int i = 0; i < NC; i++) begin
      row_re[i] = 0;
      row_im[i] = 0;
      vec_re[i] = 0;
      vec_im[i] = 0;
      for (int j = 0; j < NC; j++) begin
        gram_re[i][j] = 0;
        gram_im[i][j] = 0;
      end
    end
    energy   = 0;
    sat_seen = 1'b0;
  endtask

  // rhs closes the row: upper triangle of conj(a)*a, conj(a)*b and |b|^2
  task automatic close_row(longint br, longint bi);
    for (int i = 0; i < NC; i++) begin
      for (int j = i; j < NC; j++) begin
        gram_re[i][j] = sat_accumulate(gram_re[i][j],
                                       row_re[i] * row_re[j] + row_im[i] * row_im[j]);
        gram_im[i][j] = sat_accumulate(gram_im[i][j],
                                       row_re[i] * row_im[j] - row_im[i] * row_re[j]);
      end
      vec_re[i] = sat_accumulate(vec_re[i], row_re[i] * br + row_im[i] * bi);
      vec_im[i] = sat_accumulate(vec_im[i], row_re[i] * bi - row_im[i] * br);
    end
    energy = sat_accumulate(energy, br * br + bi * bi);
    for (int i = 0; i < NC; i++) begin
      row_re[i] = 0;
      row_im[i] = 0;
    end
  endtask

  function automatic readback_t predict_read(logic [1:0] target, logic [3:0] row,
                                             logic [3:0] col);
    longint    ore;
    longint    oim;
    readback_t r;
    ore = 0;
    oim = 0;
    case (target)
      TGT_GRAM: begin
        if (row < NC && col < NC) begin
          if (row <= col) begin
            ore = gram_re[row][col];
            oim = gram_im[row][col];
          end else begin
            // lower entry is the conjugate, negation clips without flagging
            ore = gram_re[col][row];
            oim = (gram_im[col][row] == ACC_MIN) ? ACC_MAX : -gram_im[col][row];
          end
        end
      end
      TGT_VEC: begin
        if (row < NC) begin
          ore = vec_re[row];
          oim = vec_im[row];
        end
      end
      TGT_ENERGY: ore = energy;
      default: ;
    endcase
    r.re  = ore[OUT_BITS-1:0];
    r.im  = oim[OUT_BITS-1:0];
    r.sat = sat_seen;
    return r;
  endfunction

  task automatic note_field(string name, logic [OUT_BITS-1:0] want, logic [OUT_BITS-1:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    readback_t want;
    if (reads_awaited.size() == 0) begin
      fault_count++;
      $display("%0t: result beat expected none actual re %h im %h", $time,
               m_axis_tdata[OUT_BITS-1:0], m_axis_tdata[2*OUT_BITS-1:OUT_BITS]);
    end else begin
      want = reads_awaited.pop_front();
      note_field("out_re", want.re, m_axis_tdata[OUT_BITS-1:0]);
      note_field("out_im", want.im, m_axis_tdata[2*OUT_BITS-1:OUT_BITS]);
      note_field("saturated", OUT_BITS'(want.sat), OUT_BITS'(m_axis_tuser[0]));
    end
  endtask

  task automatic take_beat();
    logic [1:0] kind;
    logic [1:0] target;
    logic [3:0] col;
    logic [3:0] row;
    kind   = s_axis_tuser[1:0];
    target = s_axis_tuser[3:2];
    col    = s_axis_tdata[3:0];
    row    = s_axis_tdata[39:36];
    case (kind)
      KIND_ELEM: begin
        if (col < NC) begin
          row_re[col] = to_sample(s_axis_tdata[19:4]);
          row_im[col] = to_sample(s_axis_tdata[35:20]);
        end
      end
      KIND_RHS:   close_row(to_sample(s_axis_tdata[19:4]), to_sample(s_axis_tdata[35:20]));
      KIND_CLEAR: clear_stores();
      default:    reads_awaited.push_back(predict_read(target, row, col));
    endcase
  endtask

  // result beats first: a read taken at this edge cannot answer at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_stores();
      reads_awaited.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_result();
      if (s_axis_tvalid && s_axis_tready)
        take_beat();
    end
    mismatches    <= fault_count;
    reads_pending <= reads_awaited.size();
  end

endmodule

// ----- tb/tb_complex_normal_equation_accumulator.sv -----
// testbench top for the complex normal-equation accumulator: clock, reset, beat stimulus,
// random back-pressure and the final verdict; checking lives in cnea_gram_checker
// depends on cnea_pkg, cnea_gram_checker and the block itself
module tb_complex_normal_equation_accumulator;
  import cnea_pkg::*;

  localparam int NC          = COEFFS_DEF;
  localparam int TOTAL_BEATS = 1220;
  localparam int TAIL_CYCLES = 400;

  // read target with no store behind it
  localparam logic [1:0] TGT_NONE = 2'd3;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // col_index[3:0], re_part[19:4], im_part[35:20], row_index[39:36]
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // kind[1:0], read_target[3:2]
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // out_re[47:0], out_im[95:48]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // saturated[0]
  logic [OUT_USER_W-1:0] m_axis_tuser;

  int mismatches;
  int reads_pending;
  int beats_sent = 0;
  bit steady     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  complex_normal_equation_accumulator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  cnea_gram_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .reads_pending (reads_pending)
  );

  // receiver stalls at random, with odds of 18 in a hundred, outside the steady stretch
  always @(posedge clk)
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);

  // one beat with random idle cycles ahead of it; valid is left high after the beat
  task automatic send_beat(logic [1:0] kind, logic [3:0] col, logic [15:0] re,
                           logic [15:0] im, logic [1:0] target, logic [3:0] row);
    while (!steady && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, im, re, col};
    s_axis_tuser  <= {target, kind};
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic elem(logic [3:0] col, logic [15:0] re, logic [15:0] im);
    send_beat(KIND_ELEM, col, re, im, 2'($urandom), 4'($urandom));
  endtask

  task automatic close_row(logic [15:0] re, logic [15:0] im);
    send_beat(KIND_RHS, 4'($urandom), re, im, 2'($urandom), 4'($urandom));
  endtask

  task automatic read_at(logic [1:0] target, logic [3:0] row, logic [3:0] col);
    send_beat(KIND_READ, col, 16'($urandom), 16'($urandom), target, row);
  endtask

  // hold the sender off until every awaited read has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (reads_pending != 0);
  endtask

  // samples lean towards the extremes so the accumulators grow fast
  function automatic logic [15:0] rand_sample();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'hffff;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic random_read();
    read_at(2'($urandom_range(0, 3)), 4'($urandom_range(0, NC - 1)),
            4'($urandom_range(0, NC - 1)));
  endtask

  // extremes, every kind and target, lower-triangle conjugate, clear
  task automatic run_directed();
    read_at(TGT_ENERGY, 4'd0, 4'd0);
    read_at(TGT_NONE, 4'd15, 4'd15);
    elem(4'd0, 16'h7fff, 16'h8000);
    elem(4'd15, 16'h8000, 16'h7fff);
    elem(4'd7, 16'hffff, 16'h0001);
    close_row(16'h8000, 16'h8000);
    read_at(TGT_GRAM, 4'd0, 4'd0);
    read_at(TGT_GRAM, 4'd0, 4'd15);
    read_at(TGT_GRAM, 4'd15, 4'd0);
    read_at(TGT_GRAM, 4'd15, 4'd15);
    read_at(TGT_GRAM, 4'd15, 4'd7);
    read_at(TGT_VEC, 4'd0, 4'd0);
    read_at(TGT_VEC, 4'd15, 4'd3);
    read_at(TGT_ENERGY, 4'd9, 4'd9);
    close_row(16'h7fff, 16'h7fff);
    read_at(TGT_ENERGY, 4'd0, 4'd0);
    read_at(TGT_GRAM, 4'd7, 4'd7);
    elem(4'd3, 16'h1234, 16'hedcb);
    send_beat(KIND_CLEAR, 4'hf, 16'hffff, 16'hffff, TGT_NONE, 4'hf);
    read_at(TGT_GRAM, 4'd0, 4'd0);
    read_at(TGT_ENERGY, 4'd0, 4'd0);
    close_row(16'h0001, 16'hffff);
    read_at(TGT_VEC, 4'd3, 4'd0);
    read_at(TGT_ENERGY, 4'd0, 4'd0);
  endtask

  task automatic run_random();
    int  pick;
    bit  drained;
    drained = 1'b0;
    while (beats_sent < TOTAL_BEATS) begin
      steady = (beats_sent >= 400 && beats_sent < 650);
      if (!drained && beats_sent >= 800) begin
        wait_drained();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed row: elements, rhs, then a few reads
        repeat ($urandom_range(1, NC))
          elem(4'($urandom_range(0, NC - 1)), rand_sample(), rand_sample());
        close_row(rand_sample(), rand_sample());
        repeat ($urandom_range(1, 4)) random_read();
      end else if (pick < 85) begin
        // back-to-back reads pile up behind the output register
        repeat ($urandom_range(1, 6)) random_read();
      end else if (pick < 88) begin
        send_beat(KIND_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom),
                  2'($urandom), 4'($urandom));
      end else begin
        // noise: any kind with any fields
        repeat ($urandom_range(1, 4))
          send_beat(2'($urandom), 4'($urandom), rand_sample(), rand_sample(),
                    2'($urandom), 4'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // main sequence and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/cnea_pkg.sv
hdl/cnea_ctrl.sv
hdl/cnea_row_mem.sv
hdl/cnea_gram_acc.sv
hdl/complex_normal_equation_accumulator.sv
tb/cnea_gram_checker.sv
tb/tb_complex_normal_equation_accumulator.sv
